### hw/rtl/hbp_pkg.sv
`timescale 1ns / 1ps

package hbp_pkg;

  // Predictor schemes selected by the mode register.
  localparam logic [1:0] MODE_SMITH   = 2'd0;
  localparam logic [1:0] MODE_BIMODAL = 2'd1;
  localparam logic [1:0] MODE_GSHARE  = 2'd2;
  localparam logic [1:0] MODE_HYBRID  = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMITH_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GSH_BITS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIST_BITS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIM_BITS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHO_BITS   = 3'd5;
  localparam int unsigned CFG_DATA_W = 4;

  // Register reset values.
  localparam logic [1:0] MODE_RST = MODE_GSHARE;
  localparam logic [3:0] SMITH_BITS_RST = 4'd3;
  localparam logic [3:0] GSH_BITS_RST   = 4'd12;
  localparam logic [3:0] HIST_BITS_RST  = 4'd8;
  localparam logic [3:0] BIM_BITS_RST   = 4'd12;
  localparam logic [3:0] CHO_BITS_RST   = 4'd12;

  // Counter widths and initial values.
  localparam int unsigned CNT_W = 3;
  localparam int unsigned CHO_W = 2;
  localparam logic [CNT_W-1:0] CNT_INIT = 3'd4;
  localparam logic [CNT_W-1:0] CNT_MAX  = 3'd7;
  localparam logic [CHO_W-1:0] CHO_INIT = 2'd1;
  localparam logic [CHO_W-1:0] CHO_MAX  = 2'd3;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // Write enables of the three counter tables.
  typedef struct packed {
    logic bim;
    logic gsh;
    logic cho;
  } tbl_we_t;

  // Saturating 3-bit counter training step.
  function automatic logic [CNT_W-1:0] train3(input logic [CNT_W-1:0] c, input logic t);
    logic [CNT_W-1:0] r;
    r = c;
    if (t) begin
      if (c != CNT_MAX) r = c + 3'd1;
    end else begin
      if (c != '0) r = c - 3'd1;
    end
    return r;
  endfunction

endpackage

### hw/rtl/hbp_tables.sv
`timescale 1ns / 1ps

module hbp_tables #(
  parameter int unsigned IW = 12
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [IW-1:0]              bim_rd_idx,
  input  logic [IW-1:0]              gsh_rd_idx,
  input  logic [IW-1:0]              cho_rd_idx,
  input  hbp_pkg::tbl_we_t           we,
  input  logic [IW-1:0]              bim_wr_idx,
  input  logic [IW-1:0]              gsh_wr_idx,
  input  logic [IW-1:0]              cho_wr_idx,
  input  logic [hbp_pkg::CNT_W-1:0]  bim_wr_data,
  input  logic [hbp_pkg::CNT_W-1:0]  gsh_wr_data,
  input  logic [hbp_pkg::CHO_W-1:0]  cho_wr_data,
  output logic [hbp_pkg::CNT_W-1:0]  bim_q,
  output logic [hbp_pkg::CNT_W-1:0]  gsh_q,
  output logic [hbp_pkg::CHO_W-1:0]  cho_q
);

  localparam int unsigned DEPTH = 1 << IW;

  logic [hbp_pkg::CNT_W-1:0] bim_mem [DEPTH];
  logic [hbp_pkg::CNT_W-1:0] gsh_mem [DEPTH];
  logic [hbp_pkg::CHO_W-1:0] cho_mem [DEPTH];

  logic [hbp_pkg::CNT_W-1:0] bim_q_r;
  logic [hbp_pkg::CNT_W-1:0] gsh_q_r;
  logic [hbp_pkg::CHO_W-1:0] cho_q_r;

  // One write port per table.
  always_ff @(posedge clk) begin
    if (we.bim) begin
      bim_mem[bim_wr_idx] <= bim_wr_data;
    end
    if (we.gsh) begin
      gsh_mem[gsh_wr_idx] <= gsh_wr_data;
    end
    if (we.cho) begin
      cho_mem[cho_wr_idx] <= cho_wr_data;
    end
  end

  // Registered read ports; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      bim_q_r <= bim_mem[bim_rd_idx];
      gsh_q_r <= gsh_mem[gsh_rd_idx];
      cho_q_r <= cho_mem[cho_rd_idx];
    end
  end

  assign bim_q = bim_q_r;
  assign gsh_q = gsh_q_r;
  assign cho_q = cho_q_r;

endmodule

### hw/rtl/hybrid_branch_predictor_core.sv
// Flow: a branch accepted in idle has its table entries read and captured, then its prediction
// is registered onto out_tdata once the output register is free or being emptied; in_tready stays
// low until then, so a branch's table read and its write-back form one read-modify-write pass.
// Reset: configuration registers, history and the smith counter load their reset values,
// then a clearing pass writes all 2^MAX_INDEX_BITS table entries before in_tready rises.
`timescale 1ns / 1ps

module hybrid_branch_predictor_core #(
  parameter int unsigned MAX_INDEX_BITS = 12,
  parameter int unsigned MAX_SMITH_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input transfer: [31:0] branch_address, [32] taken, [39:33] zero.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [39:0]                       in_tdata,
  // Result transfer: [0] predicted_taken, [1] mispredicted, [7:2] zero.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hbp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hbp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned IW = MAX_INDEX_BITS;
  localparam int unsigned SW = MAX_SMITH_BITS;

  // Mask of the low index bits for an index-width register (0 acts as 1, clipped at IW).
  function automatic logic [IW-1:0] idx_mask(input logic [3:0] r);
    logic [IW-1:0] m;
    for (int i = 0; i < IW; i++) begin
      m[i] = (i == 0) || (int'(r) > i);
    end
    return m;
  endfunction

  // Mask of the history bits in use (0 means no history).
  function automatic logic [IW-1:0] hist_mask(input logic [3:0] r);
    logic [IW-1:0] m;
    for (int i = 0; i < IW; i++) begin
      m[i] = int'(r) > i;
    end
    return m;
  endfunction

  // Largest value of the smith counter for a width register.
  function automatic logic [SW-1:0] smith_mask(input logic [3:0] r);
    logic [SW-1:0] m;
    for (int i = 0; i < SW; i++) begin
      m[i] = (i == 0) || (int'(r) > i);
    end
    return m;
  endfunction

  // Midpoint of the smith counter: the top bit of its range.
  function automatic logic [SW-1:0] smith_mid(input logic [3:0] r);
    logic [SW-1:0] m;
    m = smith_mask(r);
    return m & ~(m >> 1);
  endfunction

  // Configuration registers.
  logic [1:0] mode_r;
  logic [3:0] smith_bits_r;
  logic [3:0] gsh_bits_r;
  logic [3:0] hist_bits_r;
  logic [3:0] bim_bits_r;
  logic [3:0] cho_bits_r;

  // Predictor state outside the memories.
  logic [SW-1:0] smith_r, smith_nxt;
  logic [IW-1:0] ghist_r, ghist_nxt;

  // Sequencer.
  hbp_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]   clr_idx_r;
  logic            accept;
  logic            fire;

  // Captured branch and table indexes.
  logic          taken_r;
  logic [IW-1:0] bim_idx_r;
  logic [IW-1:0] gsh_idx_r;
  logic [IW-1:0] cho_idx_r;

  // Output register.
  logic out_tvalid_r;
  logic pred_r, pred_nxt;
  logic mis_r;

  // Read address computation.
  logic [31:0]   addr;
  logic [IW-1:0] addr_bits;
  logic [IW-1:0] hist_val;
  logic [IW-1:0] bim_rd_idx;
  logic [IW-1:0] gsh_rd_idx;
  logic [IW-1:0] cho_rd_idx;

  // Table interface.
  hbp_pkg::tbl_we_t            tbl_we, upd_we;
  logic [IW-1:0]               bim_wr_idx, gsh_wr_idx, cho_wr_idx;
  logic [hbp_pkg::CNT_W-1:0]   bim_wr_data, gsh_wr_data;
  logic [hbp_pkg::CHO_W-1:0]   cho_wr_data;
  logic [hbp_pkg::CNT_W-1:0]   bim_q, gsh_q;
  logic [hbp_pkg::CHO_W-1:0]   cho_q;
  logic [hbp_pkg::CNT_W-1:0]   bim_upd, gsh_upd;
  logic [hbp_pkg::CHO_W-1:0]   cho_upd;

  // Update-cycle decode.
  logic          bim_pred, gsh_pred;
  logic [SW-1:0] smith_hi;
  logic [IW-1:0] hmask;
  logic [IW-1:0] hist_top;

  assign cfg_ready = 1'b1;

  // Table indexes of the branch being offered.
  always_comb begin
    addr      = in_tdata[31:0];
    addr_bits = addr[IW+1:2];
    hist_val  = ghist_r & hist_mask(hist_bits_r);
    bim_rd_idx = addr_bits & idx_mask(bim_bits_r);
    cho_rd_idx = addr_bits & idx_mask(cho_bits_r);
    if (mode_r == hbp_pkg::MODE_GSHARE || mode_r == hbp_pkg::MODE_HYBRID) begin
      gsh_rd_idx = (addr_bits ^ hist_val) & idx_mask(gsh_bits_r);
    end else begin
      gsh_rd_idx = addr_bits & idx_mask(gsh_bits_r);
    end
  end

  // Sequencer: clearing pass, idle, and the read-modify-write step.
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    accept    = 1'b0;
    fire      = 1'b0;
    case (state_r)
      hbp_pkg::ST_CLEAR: begin
        if (&clr_idx_r) begin
          state_nxt = hbp_pkg::ST_IDLE;
        end
      end
      hbp_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        accept    = in_tvalid;
        if (in_tvalid) begin
          state_nxt = hbp_pkg::ST_UPDATE;
        end
      end
      hbp_pkg::ST_UPDATE: begin
        fire = !out_tvalid_r || out_tready;
        if (fire) begin
          state_nxt = hbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hbp_pkg::ST_IDLE;
      end
    endcase
  end

  // Prediction and training of the branch whose table entries were last read.
  always_comb begin
    bim_pred = bim_q >= hbp_pkg::CNT_INIT;
    gsh_pred = gsh_q >= hbp_pkg::CNT_INIT;
    smith_hi = smith_mask(smith_bits_r);
    hmask    = hist_mask(hist_bits_r);
    hist_top = hmask & ~(hmask >> 1);
    bim_upd  = hbp_pkg::train3(bim_q, taken_r);
    gsh_upd  = hbp_pkg::train3(gsh_q, taken_r);

    // Chooser moves toward the predictor that alone was right.
    cho_upd = cho_q;
    if (gsh_pred == taken_r && bim_pred != taken_r) begin
      if (cho_q != hbp_pkg::CHO_MAX) cho_upd = cho_q + 2'd1;
    end else if (gsh_pred != taken_r && bim_pred == taken_r) begin
      if (cho_q != '0) cho_upd = cho_q - 2'd1;
    end

    pred_nxt  = 1'b0;
    smith_nxt = smith_r;
    ghist_nxt = ghist_r;
    upd_we    = '0;
    case (mode_r)
      hbp_pkg::MODE_SMITH: begin
        pred_nxt = smith_r >= smith_mid(smith_bits_r);
        if (taken_r) begin
          if (smith_r < smith_hi) smith_nxt = smith_r + 1'b1;
        end else begin
          if (smith_r != '0) smith_nxt = smith_r - 1'b1;
        end
        if (smith_nxt > smith_hi) smith_nxt = smith_hi;
      end
      hbp_pkg::MODE_BIMODAL: begin
        pred_nxt   = gsh_pred;
        upd_we.gsh = 1'b1;
      end
      hbp_pkg::MODE_GSHARE: begin
        pred_nxt   = gsh_pred;
        upd_we.gsh = 1'b1;
        ghist_nxt  = ((ghist_r & hmask) >> 1) | (taken_r ? hist_top : '0);
      end
      default: begin
        if (!cho_q[1]) begin
          pred_nxt   = bim_pred;
          upd_we.bim = 1'b1;
        end else begin
          pred_nxt   = gsh_pred;
          upd_we.gsh = 1'b1;
        end
        upd_we.cho = 1'b1;
        ghist_nxt  = ((ghist_r & hmask) >> 1) | (taken_r ? hist_top : '0);
      end
    endcase
  end

  // Write port: the clearing pass, or the write-back of a finished update.
  always_comb begin
    if (state_r == hbp_pkg::ST_CLEAR) begin
      tbl_we      = '{bim: 1'b1, gsh: 1'b1, cho: 1'b1};
      bim_wr_idx  = clr_idx_r;
      gsh_wr_idx  = clr_idx_r;
      cho_wr_idx  = clr_idx_r;
      bim_wr_data = hbp_pkg::CNT_INIT;
      gsh_wr_data = hbp_pkg::CNT_INIT;
      cho_wr_data = hbp_pkg::CHO_INIT;
    end else begin
      tbl_we      = fire ? upd_we : '0;
      bim_wr_idx  = bim_idx_r;
      gsh_wr_idx  = gsh_idx_r;
      cho_wr_idx  = cho_idx_r;
      bim_wr_data = bim_upd;
      gsh_wr_data = gsh_upd;
      cho_wr_data = cho_upd;
    end
  end

  hbp_tables #(
    .IW (IW)
  ) u_tables (
    .clk         (clk),
    .rd_en       (accept),
    .bim_rd_idx  (bim_rd_idx),
    .gsh_rd_idx  (gsh_rd_idx),
    .cho_rd_idx  (cho_rd_idx),
    .we          (tbl_we),
    .bim_wr_idx  (bim_wr_idx),
    .gsh_wr_idx  (gsh_wr_idx),
    .cho_wr_idx  (cho_wr_idx),
    .bim_wr_data (bim_wr_data),
    .gsh_wr_data (gsh_wr_data),
    .cho_wr_data (cho_wr_data),
    .bim_q       (bim_q),
    .gsh_q       (gsh_q),
    .cho_q       (cho_q)
  );

  // Sequencer and clearing counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= hbp_pkg::ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == hbp_pkg::ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  // Configuration registers, smith counter and global history.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= hbp_pkg::MODE_RST;
      smith_bits_r <= hbp_pkg::SMITH_BITS_RST;
      gsh_bits_r   <= hbp_pkg::GSH_BITS_RST;
      hist_bits_r  <= hbp_pkg::HIST_BITS_RST;
      bim_bits_r   <= hbp_pkg::BIM_BITS_RST;
      cho_bits_r   <= hbp_pkg::CHO_BITS_RST;
      smith_r      <= smith_mid(hbp_pkg::SMITH_BITS_RST);
      ghist_r      <= '0;
    end else begin
      if (fire) begin
        smith_r <= smith_nxt;
        ghist_r <= ghist_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hbp_pkg::CFG_MODE:       mode_r <= cfg_data[1:0];
          hbp_pkg::CFG_SMITH_BITS: begin
            smith_bits_r <= cfg_data;
            smith_r      <= smith_mid(cfg_data);
          end
          hbp_pkg::CFG_GSH_BITS:   gsh_bits_r  <= cfg_data;
          hbp_pkg::CFG_HIST_BITS:  hist_bits_r <= cfg_data;
          hbp_pkg::CFG_BIM_BITS:   bim_bits_r  <= cfg_data;
          hbp_pkg::CFG_CHO_BITS:   cho_bits_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Branch capture on an input transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      taken_r   <= in_tdata[32];
      bim_idx_r <= bim_rd_idx;
      gsh_idx_r <= gsh_rd_idx;
      cho_idx_r <= cho_rd_idx;
    end
  end

  // Output register: loaded by an update, emptied by a result transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pred_r <= pred_nxt;
      mis_r  <= pred_nxt ^ taken_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'b0, mis_r, pred_r};

endmodule
